### hw/rtl/task_event_flag_unit_macros.svh
// ----------------------------------------------------------------------------
// task event flag unit assertion macros
// shared concurrent assertion forms, clocked on clock and held off in reset
// ----------------------------------------------------------------------------
`ifndef TASK_EVENT_FLAG_UNIT_MACROS_SVH
`define TASK_EVENT_FLAG_UNIT_MACROS_SVH

// same-cycle implication
`define TEFU_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define TEFU_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hw/rtl/tefu_pkg.sv
// ----------------------------------------------------------------------------
// tefu_pkg
// widths, request and status codes, payload types and the wake condition
// ----------------------------------------------------------------------------
`default_nettype none

package tefu_pkg;

   localparam int TASK_ID_W     = 5;
   localparam int MASK_W        = 32;
   localparam int MODE_W        = 2;
   localparam int KIND_W        = 2;
   localparam int STATUS_W      = 3;
   localparam int TASKS_DEFAULT = 16;

   // recv_mode bits
   localparam int MODE_ANY_BIT    = 0;
   localparam int MODE_NOWAIT_BIT = 1;

   typedef enum logic [KIND_W-1:0] {
      REQ_RECV    = 2'd0,
      REQ_SEND    = 2'd1,
      REQ_TIMEOUT = 2'd2
   } req_kind_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK      = 3'd0,
      ST_NOEVS   = 3'd1,
      ST_TIMEOUT = 3'd2,
      ST_BADTASK = 3'd3,
      ST_PENDING = 3'd4,
      ST_BUSY    = 3'd5
   } status_type;

   typedef struct packed {
      logic [KIND_W-1:0]    req_type;
      logic [TASK_ID_W-1:0] task_id;
      logic [MASK_W-1:0]    event_mask;
      logic [MODE_W-1:0]    recv_mode;
   } req_payload_type;

   typedef struct packed {
      status_type        status;
      logic [MASK_W-1:0] events_out;
      logic              woke_task;
      logic [MASK_W-1:0] woke_events;
   } rsp_payload_type;

   function automatic logic cond_met(input logic [MASK_W-1:0] word,
                                     input logic [MASK_W-1:0] mask,
                                     input logic              any);
      logic [MASK_W-1:0] hit;
      hit = word & mask;
      if (any) begin
         return (hit != '0);
      end
      return (hit == mask);
   endfunction

endpackage

`default_nettype wire

### hw/rtl/tefu_ifs.sv
// ----------------------------------------------------------------------------
// tefu channel interfaces
// valid/ready request and response channels of the event flag unit
// ----------------------------------------------------------------------------
`default_nettype none

interface tefu_req_if import tefu_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [KIND_W-1:0]    req_type;
   logic [TASK_ID_W-1:0] task_id;
   logic [MASK_W-1:0]    event_mask;
   logic [MODE_W-1:0]    recv_mode;

   modport source (output valid, req_type, task_id, event_mask, recv_mode, input ready);
   modport sink   (input valid, req_type, task_id, event_mask, recv_mode, output ready);
endinterface

interface tefu_rsp_if import tefu_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [STATUS_W-1:0]  status;
   logic [MASK_W-1:0]    events_out;
   logic                 woke_task;
   logic [MASK_W-1:0]    woke_events;

   modport source (output valid, status, events_out, woke_task, woke_events, input ready);
   modport sink   (input valid, status, events_out, woke_task, woke_events, output ready);
endinterface

`default_nettype wire

### hw/rtl/task_event_flag_unit.sv
// ----------------------------------------------------------------------------
// task event flag unit
// per-task event flag words with send, receive, pending wait and timeout
//
// usage:
//  - req_ch carries one request (receive, send or timeout) per valid/ready
//    handshake; rsp_ch returns exactly one response per request, in order
//  - a request is held in an input register, processed against the
//    addressed task entry (one read-modify-write) once the output register
//    can take its response, and the response is written to that register
//  - throughput: one request per cycle while rsp_ch is not stalled, set by
//    the single read-modify-write of the task table per cycle
//  - a stalled rsp_ch holds the response; one more request is taken into
//    the input register, then req_ch.ready drops until the response drains
//  - reset clears all flag words, wait marks, wait masks and both valid
//    flags; requests are taken from the first cycle after reset
// ----------------------------------------------------------------------------
`default_nettype none

`include "task_event_flag_unit_macros.svh"

module task_event_flag_unit import tefu_pkg::*; #(
   parameter int NUM_TASKS = TASKS_DEFAULT
) (
   input  wire      clock,
   input  wire      reset,
   tefu_req_if.sink   req_ch,
   tefu_rsp_if.source rsp_ch
);

   localparam int IDX_W = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
   localparam logic [TASK_ID_W:0] TASK_LIMIT = (TASK_ID_W + 1)'(NUM_TASKS);

   // task table
   logic [MASK_W-1:0] flag_word_ff [NUM_TASKS];
   logic              is_waiting_ff[NUM_TASKS];
   logic [MASK_W-1:0] wait_mask_ff [NUM_TASKS];
   logic              wait_any_ff  [NUM_TASKS];

   req_payload_type in_ff;
   logic            in_vld_ff, in_vld_in;
   rsp_payload_type rsp_ff, rsp_in;
   logic            out_vld_ff, out_vld_in;

   logic              accept, advance, process;
   logic              id_ok;
   logic [IDX_W-1:0]  idx;
   req_kind_type      kind;
   logic              any, nowait;
   logic [MASK_W-1:0] word, wmask, bits, sum;
   logic              waiting, wany;
   logic [MASK_W-1:0] word_in, wmask_in;
   logic              waiting_in, wany_in;

   assign advance      = !out_vld_ff || rsp_ch.ready;
   assign process      = in_vld_ff && advance;
   assign req_ch.ready = !in_vld_ff || advance;
   assign accept       = req_ch.valid && req_ch.ready;

   assign in_vld_in  = accept ? 1'b1 : (advance ? 1'b0 : in_vld_ff);
   assign out_vld_in = process ? 1'b1 : (rsp_ch.ready ? 1'b0 : out_vld_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_ff.req_type   <= req_ch.req_type;
         in_ff.task_id    <= req_ch.task_id;
         in_ff.event_mask <= req_ch.event_mask;
         in_ff.recv_mode  <= req_ch.recv_mode;
      end
      if (process) begin
         rsp_ff <= rsp_in;
      end
   end

   // entry read
   assign id_ok   = ({1'b0, in_ff.task_id} < TASK_LIMIT);
   assign idx     = in_ff.task_id[IDX_W-1:0];
   assign kind    = req_kind_type'(in_ff.req_type);
   assign any     = in_ff.recv_mode[MODE_ANY_BIT];
   assign nowait  = in_ff.recv_mode[MODE_NOWAIT_BIT];
   assign word    = flag_word_ff[idx];
   assign waiting = is_waiting_ff[idx];
   assign wmask   = wait_mask_ff[idx];
   assign wany    = wait_any_ff[idx];
   assign bits    = word & in_ff.event_mask;
   assign sum     = word | in_ff.event_mask;

   always_comb begin
      rsp_in.status      = ST_OK;
      rsp_in.events_out  = '0;
      rsp_in.woke_task   = 1'b0;
      rsp_in.woke_events = '0;
      word_in            = word;
      waiting_in         = waiting;
      wmask_in           = wmask;
      wany_in            = wany;
      if (!id_ok) begin
         rsp_in.status = ST_BADTASK;
      end else begin
         case (kind)
            REQ_RECV: begin
               if (waiting) begin
                  rsp_in.status = ST_BUSY;
               end else if (in_ff.event_mask == '0) begin
                  rsp_in.events_out = word;
               end else if (nowait) begin
                  rsp_in.events_out = bits;
                  word_in           = word & ~in_ff.event_mask;
                  if (!cond_met(bits, in_ff.event_mask, any)) begin
                     rsp_in.status = ST_NOEVS;
                  end
               end else if (cond_met(word, in_ff.event_mask, any)) begin
                  rsp_in.events_out = bits;
                  word_in           = word & ~in_ff.event_mask;
               end else begin
                  waiting_in    = 1'b1;
                  wmask_in      = in_ff.event_mask;
                  wany_in       = any;
                  rsp_in.status = ST_PENDING;
               end
            end
            REQ_SEND: begin
               word_in = sum;
               if (waiting && cond_met(sum, wmask, wany)) begin
                  rsp_in.woke_task   = 1'b1;
                  rsp_in.woke_events = sum & wmask;
                  word_in            = sum & ~wmask;
                  waiting_in         = 1'b0;
               end
            end
            REQ_TIMEOUT: begin
               if (waiting) begin
                  rsp_in.status     = ST_TIMEOUT;
                  rsp_in.events_out = wmask;
                  waiting_in        = 1'b0;
               end else begin
                  rsp_in.status = ST_BUSY;
               end
            end
            default: begin
               rsp_in.status = ST_BUSY;
            end
         endcase
      end
   end

   // entry write
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_TASKS; i++) begin
            flag_word_ff[i]  <= '0;
            is_waiting_ff[i] <= 1'b0;
            wait_mask_ff[i]  <= '0;
            wait_any_ff[i]   <= 1'b0;
         end
      end else if (process && id_ok) begin
         flag_word_ff[idx]  <= word_in;
         is_waiting_ff[idx] <= waiting_in;
         wait_mask_ff[idx]  <= wmask_in;
         wait_any_ff[idx]   <= wany_in;
      end
   end

   assign rsp_ch.valid       = out_vld_ff;
   assign rsp_ch.status      = rsp_ff.status;
   assign rsp_ch.events_out  = rsp_ff.events_out;
   assign rsp_ch.woke_task   = rsp_ff.woke_task;
   assign rsp_ch.woke_events = rsp_ff.woke_events;

   `TEFU_ASSERT_NOW(a_woke_ok, process && rsp_in.woke_task, rsp_in.status == ST_OK, "wake without ok status")
   `TEFU_ASSERT_NEXT(a_woke_clears_wait, process && rsp_in.woke_task, !is_waiting_ff[$past(idx)], "woken task still waiting")
   `TEFU_ASSERT_NEXT(a_pending_sets_wait, process && rsp_in.status == ST_PENDING, is_waiting_ff[$past(idx)], "pending wait not recorded")
   `TEFU_ASSERT_NEXT(a_stall_holds_req, in_vld_ff && !advance, in_vld_ff && $stable(in_ff), "held request lost")

endmodule

`default_nettype wire
